// ===== rtl/vcfv_pkg.sv =====
// ----------------------------------------------------------------------------
// vcfv_pkg: shared types and constants for the voxel face visibility core
// Command codes, payload structs and default sizes for the chunk stores.
// ----------------------------------------------------------------------------
package vcfv_pkg;

    // default chunk geometry and type code width
    localparam int EDGE_BITS_DEF = 4;
    localparam int TYPE_BITS_DEF = 8;

    // fixed field widths of the command and result payloads
    localparam int CMD_W   = 2;
    localparam int POS_W   = 4;
    localparam int CODE_W  = 8;
    localparam int MASK_W  = 8;

    // mask stored for an empty block
    localparam logic [MASK_W-1:0] MASK_EMPTY = 8'hFF;

    // command codes
    localparam logic [CMD_W-1:0] CMD_WRITE_TYPE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REBUILD    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ_MASK  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ_TYPE  = 2'd3;

    // one command transfer
    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic [POS_W-1:0]  pos_z;
        logic [CODE_W-1:0] new_type;
    } t_cmd;

    // one result transfer
    typedef struct packed {
        logic [MASK_W-1:0] face_mask;
        logic [CODE_W-1:0] type_out;
    } t_result;

endpackage

// ===== rtl/voxel_chunk_face_visibility_core.sv =====
// ----------------------------------------------------------------------------
// voxel_chunk_face_visibility_core: voxel chunk store with face culling
// Holds a block type store and a visible-face mask store for a cubic chunk,
// serves type writes and reads, and rebuilds all masks on command.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                 Payload
// command   in         start && !busy            i_cmd (t_cmd)
// result    out        o_res_stb, one cycle      o_res (t_result)
// config    in         i_cfg_we                  i_cfg_wdata (air code)
//
// A read result shows in the cycle after its
// transfer, on a strobe that cannot be held off, so nothing stalls the output.
// A rebuild visits each cell in turn (self read, six neighbor reads, mask
// write), with busy high throughout.
// After reset a clearing pass fills both stores with busy high; config
// writes land in any cycle.
module voxel_chunk_face_visibility_core #(
    parameter int EDGE_BITS = vcfv_pkg::EDGE_BITS_DEF,
    parameter int TYPE_BITS = vcfv_pkg::TYPE_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  vcfv_pkg::t_cmd             i_cmd,
    output logic                       o_res_stb,
    output vcfv_pkg::t_result          o_res,
    input  logic                       i_cfg_we,
    input  logic [vcfv_pkg::CODE_W-1:0] i_cfg_wdata
);

    localparam int ADDR_BITS  = 3 * EDGE_BITS;
    localparam int CELL_COUNT = 1 << ADDR_BITS;

    // sequencer states
    localparam logic [1:0] S_CLEAR   = 2'd0;
    localparam logic [1:0] S_IDLE    = 2'd1;
    localparam logic [1:0] S_REBUILD = 2'd2;

    // rebuild phases: read issue order, then mask write
    localparam logic [2:0] PH_SELF  = 3'd0;
    localparam logic [2:0] PH_XN    = 3'd1;
    localparam logic [2:0] PH_XP    = 3'd2;
    localparam logic [2:0] PH_YN    = 3'd3;
    localparam logic [2:0] PH_YP    = 3'd4;
    localparam logic [2:0] PH_ZN    = 3'd5;
    localparam logic [2:0] PH_ZP    = 3'd6;
    localparam logic [2:0] PH_WRITE = 3'd7;

    // storage
    logic [TYPE_BITS-1:0]        type_mem [CELL_COUNT];
    logic [vcfv_pkg::MASK_W-1:0] mask_mem [CELL_COUNT];

    // control and payload registers
    logic [1:0]                  r_state, n_state;
    logic [ADDR_BITS-1:0]        r_cell, n_cell;
    logic [2:0]                  r_phase, n_phase;
    logic                        r_oob;
    logic                        r_self_air;
    logic [4:0]                  r_faces;
    logic [vcfv_pkg::CODE_W-1:0] r_air_code;
    logic                        r_res_stb;
    logic [TYPE_BITS-1:0]        r_type_rd;
    logic [vcfv_pkg::MASK_W-1:0] r_mask_rd;

    logic                        acc;
    logic                        acc_read;
    logic [ADDR_BITS-1:0]        in_addr;
    logic [EDGE_BITS-1:0]        cx, cy, cz;
    logic [ADDR_BITS-1:0]        nb_addr;
    logic                        nb_oob;
    logic                        air_now;
    logic [TYPE_BITS-1:0]        air_t;
    logic [vcfv_pkg::MASK_W-1:0] cell_mask;
    logic                        cell_last;

    // command transfer decode
    assign busy     = (r_state != S_IDLE);
    assign acc      = start && !busy;
    assign acc_read = acc && ((i_cmd.command == vcfv_pkg::CMD_READ_MASK) ||
                              (i_cmd.command == vcfv_pkg::CMD_READ_TYPE));
    assign in_addr  = {EDGE_BITS'(i_cmd.pos_x), EDGE_BITS'(i_cmd.pos_y),
                       EDGE_BITS'(i_cmd.pos_z)};

    // current cell coordinates
    assign cx = r_cell[ADDR_BITS-1:2*EDGE_BITS];
    assign cy = r_cell[2*EDGE_BITS-1:EDGE_BITS];
    assign cz = r_cell[EDGE_BITS-1:0];
    assign cell_last = (r_cell == {ADDR_BITS{1'b1}});

    // neighbor address for the read issued this phase; off-chunk counts as air
    always_comb begin
        nb_addr = r_cell;
        nb_oob  = 1'b0;
        unique case (r_phase)
            PH_SELF: begin
                nb_addr = r_cell;
            end
            PH_XN: begin
                nb_addr = {cx - 1'b1, cy, cz};
                nb_oob  = (cx == '0);
            end
            PH_XP: begin
                nb_addr = {cx + 1'b1, cy, cz};
                nb_oob  = (cx == {EDGE_BITS{1'b1}});
            end
            PH_YN: begin
                nb_addr = {cx, cy - 1'b1, cz};
                nb_oob  = (cy == '0);
            end
            PH_YP: begin
                nb_addr = {cx, cy + 1'b1, cz};
                nb_oob  = (cy == {EDGE_BITS{1'b1}});
            end
            PH_ZN: begin
                nb_addr = {cx, cy, cz - 1'b1};
                nb_oob  = (cz == '0);
            end
            PH_ZP: begin
                nb_addr = {cx, cy, cz + 1'b1};
                nb_oob  = (cz == {EDGE_BITS{1'b1}});
            end
            default: begin
                nb_addr = r_cell;
            end
        endcase
    end

    // air test on the read returned from the previous phase
    assign air_t     = TYPE_BITS'(r_air_code);
    assign air_now   = r_oob || (r_type_rd == air_t);
    assign cell_mask = r_self_air ? vcfv_pkg::MASK_EMPTY
                                  : {2'b00, air_now, r_faces};

    // sequencer next state
    always_comb begin
        n_state = r_state;
        n_cell  = r_cell;
        n_phase = r_phase;
        unique case (r_state)
            S_CLEAR: begin
                n_cell = r_cell + 1'b1;
                if (cell_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (acc && (i_cmd.command == vcfv_pkg::CMD_REBUILD)) begin
                    n_state = S_REBUILD;
                    n_cell  = '0;
                    n_phase = PH_SELF;
                end
            end
            S_REBUILD: begin
                n_phase = r_phase + 1'b1;
                if (r_phase == PH_WRITE) begin
                    n_cell = r_cell + 1'b1;
                    if (cell_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_CLEAR;
                n_cell  = '0;
                n_phase = PH_SELF;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_cell     <= '0;
            r_phase    <= PH_SELF;
            r_res_stb  <= 1'b0;
            r_air_code <= '0;
        end else begin
            r_state   <= n_state;
            r_cell    <= n_cell;
            r_phase   <= n_phase;
            r_res_stb <= acc_read;
            if (i_cfg_we) begin
                r_air_code <= i_cfg_wdata;
            end
        end
    end

    // rebuild face accumulation
    always_ff @(posedge i_clk) begin
        r_oob <= nb_oob;
        if (r_state == S_REBUILD) begin
            if (r_phase == PH_XN) begin
                r_self_air <= air_now;
            end
            if ((r_phase >= PH_XP) && (r_phase <= PH_ZP)) begin
                r_faces <= {air_now, r_faces[4:1]};
            end
        end
    end

    // type store: clear, command write, read for commands and rebuild
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            type_mem[r_cell] <= '0;
        end else if (acc && (i_cmd.command == vcfv_pkg::CMD_WRITE_TYPE)) begin
            type_mem[in_addr] <= TYPE_BITS'(i_cmd.new_type);
        end
        r_type_rd <= type_mem[(r_state == S_REBUILD) ? nb_addr : in_addr];
    end

    // mask store: clear, rebuild write, read for commands
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            mask_mem[r_cell] <= vcfv_pkg::MASK_EMPTY;
        end else if ((r_state == S_REBUILD) && (r_phase == PH_WRITE)) begin
            mask_mem[r_cell] <= cell_mask;
        end
        r_mask_rd <= mask_mem[in_addr];
    end

    // result transfer
    assign o_res_stb       = r_res_stb;
    assign o_res.face_mask = r_mask_rd;
    assign o_res.type_out  = vcfv_pkg::CODE_W'(r_type_rd);

    // checks
    a_stb_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_stb |-> $past(acc_read))
        else $error("result strobe without an accepted read");

    a_stb_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_stb |-> ($past(r_state) == S_IDLE))
        else $error("result strobe after a busy cycle");

    a_phase_rebuild: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_SELF) |-> (r_state == S_REBUILD))
        else $error("rebuild phase active outside rebuild");

    a_rebuild_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_REBUILD) && (r_phase == PH_WRITE) && cell_last)
        |=> (r_state == S_IDLE))
        else $error("rebuild did not end after last cell");

    a_clear_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_CLEAR) && cell_last) |=> (r_state == S_IDLE))
        else $error("clearing pass did not end after last cell");

endmodule

// ===== sim/vcfv_chunk_checker.sv =====
// ----------------------------------------------------------------------------
// vcfv_chunk_checker: scoreboard for the voxel face visibility core
// Watches the command, result and config channels, keeps its own copy of
// the type and mask stores, predicts every read result and compares it.
// ----------------------------------------------------------------------------
module vcfv_chunk_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_busy,
    input  vcfv_pkg::t_cmd              i_cmd,
    input  logic                        i_res_stb,
    input  vcfv_pkg::t_result           i_res,
    input  logic                        i_cfg_we,
    input  logic [vcfv_pkg::CODE_W-1:0] i_cfg_wdata,
    output int                          o_fail_count,
    output int                          o_pending
);

    localparam int EDGE_LEN   = 1 << vcfv_pkg::EDGE_BITS_DEF;
    localparam int CELL_COUNT = 1 << (3 * vcfv_pkg::EDGE_BITS_DEF);
    localparam int POS_W      = vcfv_pkg::POS_W;

    // shadow copies of the block's stores and air code register
    logic [vcfv_pkg::CODE_W-1:0] chunk_types [CELL_COUNT];
    logic [vcfv_pkg::MASK_W-1:0] chunk_masks [CELL_COUNT];
    logic [vcfv_pkg::CODE_W-1:0] air_code_q;

    // read results still owed by the block, oldest first
    vcfv_pkg::t_result           pending_reads [$];
    int                          fail_count = 0;

    assign o_fail_count = fail_count;

    function automatic logic [3*POS_W-1:0] cell_addr(
        input logic [POS_W-1:0] x,
        input logic [POS_W-1:0] y,
        input logic [POS_W-1:0] z
    );
        return {x, y, z};
    endfunction

    // outside the chunk counts as air
    function automatic bit neighbor_is_air(input int x, input int y, input int z);
        if (x < 0 || y < 0 || z < 0 || x >= EDGE_LEN || y >= EDGE_LEN || z >= EDGE_LEN)
            return 1'b1;
        return chunk_types[cell_addr(x[POS_W-1:0], y[POS_W-1:0], z[POS_W-1:0])]
               == air_code_q;
    endfunction

    // full mask rebuild: bit0 -x, bit1 +x, bit2 -y, bit3 +y, bit4 -z, bit5 +z
    task automatic compute_face_masks();
        logic [vcfv_pkg::MASK_W-1:0] m;
        for (int x = 0; x < EDGE_LEN; x++) begin
            for (int y = 0; y < EDGE_LEN; y++) begin
                for (int z = 0; z < EDGE_LEN; z++) begin
                    if (neighbor_is_air(x, y, z)) begin
                        m = vcfv_pkg::MASK_EMPTY;
                    end else begin
                        m = '0;
                        m[0] = neighbor_is_air(x - 1, y, z);
                        m[1] = neighbor_is_air(x + 1, y, z);
                        m[2] = neighbor_is_air(x, y - 1, z);
                        m[3] = neighbor_is_air(x, y + 1, z);
                        m[4] = neighbor_is_air(x, y, z - 1);
                        m[5] = neighbor_is_air(x, y, z + 1);
                    end
                    chunk_masks[cell_addr(x[POS_W-1:0], y[POS_W-1:0], z[POS_W-1:0])] = m;
                end
            end
        end
    endtask

    task automatic report_mismatch(
        input string       what,
        input logic [7:0]  got,
        input logic [7:0]  want
    );
        fail_count++;
        $display("mismatch at %0t: %s got %02h want %02h", $time, what, got, want);
    endtask

    // per-edge bookkeeping: results first, then config, then the new command
    always @(posedge i_clk) begin
        vcfv_pkg::t_result   want;
        logic [3*POS_W-1:0]  addr;
        if (!i_rst_n) begin
            for (int i = 0; i < CELL_COUNT; i++) begin
                chunk_types[i] = '0;
                chunk_masks[i] = vcfv_pkg::MASK_EMPTY;
            end
            air_code_q = '0;
            pending_reads.delete();
        end else begin
            // result check
            if (i_res_stb) begin
                if (pending_reads.size() == 0) begin
                    report_mismatch("unexpected result, face_mask", i_res.face_mask, 8'h00);
                end else begin
                    want = pending_reads.pop_front();
                    if (i_res.face_mask !== want.face_mask)
                        report_mismatch("face_mask", i_res.face_mask, want.face_mask);
                    if (i_res.type_out !== want.type_out)
                        report_mismatch("type_out", i_res.type_out, want.type_out);
                end
            end

            // air code register
            if (i_cfg_we)
                air_code_q = i_cfg_wdata;

            // command transfer
            if (i_start && !i_busy) begin
                addr = cell_addr(i_cmd.pos_x, i_cmd.pos_y, i_cmd.pos_z);
                case (i_cmd.command)
                    vcfv_pkg::CMD_WRITE_TYPE: begin
                        chunk_types[addr] = i_cmd.new_type;
                    end
                    vcfv_pkg::CMD_REBUILD: begin
                        compute_face_masks();
                    end
                    vcfv_pkg::CMD_READ_MASK, vcfv_pkg::CMD_READ_TYPE: begin
                        want.face_mask = chunk_masks[addr];
                        want.type_out  = chunk_types[addr];
                        pending_reads.push_back(want);
                    end
                endcase
            end
        end
        o_pending <= pending_reads.size();
    end

endmodule

// ===== sim/voxel_chunk_face_visibility_core_tb.sv =====
// ----------------------------------------------------------------------------
// voxel_chunk_face_visibility_core_tb: top of the face visibility testbench
// Drives directed and random type writes, mask rebuilds and reads over
// several air code settings, with random sender gaps; the checker beside
// the block predicts and compares every read result.
// ----------------------------------------------------------------------------
module voxel_chunk_face_visibility_core_tb;

    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int CYCLE_LIMIT     = 2_500_000;
    localparam int CMD_W           = vcfv_pkg::CMD_W;
    localparam int POS_W           = vcfv_pkg::POS_W;
    localparam int CODE_W          = vcfv_pkg::CODE_W;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    vcfv_pkg::t_cmd    i_cmd;
    logic              o_res_stb;
    vcfv_pkg::t_result o_res;
    logic              i_cfg_we;
    logic [CODE_W-1:0] i_cfg_wdata;

    int                fail_count;
    int                reads_pending;
    int                cycle_count = 0;
    int                n_writes = 0;
    int                n_rebuilds = 0;
    int                n_reads = 0;
    int                n_air_settings = 0;
    logic [CODE_W-1:0] air_now;

    voxel_chunk_face_visibility_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_res_stb   (o_res_stb),
        .o_res       (o_res),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    vcfv_chunk_checker u_chunk_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_cmd        (i_cmd),
        .i_res_stb    (o_res_stb),
        .i_res        (o_res),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (reads_pending)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d reads still owed",
                     cycle_count, reads_pending);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // one command transfer; start stays high on return
    task automatic send_cmd(
        input logic [CMD_W-1:0]  op,
        input logic [POS_W-1:0]  x,
        input logic [POS_W-1:0]  y,
        input logic [POS_W-1:0]  z,
        input logic [CODE_W-1:0] code
    );
        vcfv_pkg::t_cmd c;
        c.command  = op;
        c.pos_x    = x;
        c.pos_y    = y;
        c.pos_z    = z;
        c.new_type = code;
        i_cmd <= c;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        case (op)
            vcfv_pkg::CMD_WRITE_TYPE: n_writes++;
            vcfv_pkg::CMD_REBUILD:    n_rebuilds++;
            default:                  n_reads++;
        endcase
    endtask

    task automatic idle_gap(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // drain owed reads and let any rebuild or write finish
    task automatic settle();
        start <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (reads_pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        while (busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_air(input logic [CODE_W-1:0] code);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= code;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        air_now = code;
        n_air_settings++;
    endtask

    // corner-biased window base so the window often touches the chunk edge
    function automatic logic [POS_W-1:0] pick_base();
        case ($urandom_range(0, 3))
            0:       return 4'd0;
            1:       return 4'd12;
            default: return 4'($urandom_range(0, 12));
        endcase
    endfunction

    // mostly inside a 4-wide window so blocks end up next to each other
    function automatic logic [POS_W-1:0] pick_coord(input logic [POS_W-1:0] base);
        if ($urandom_range(0, 3) != 0)
            return base + 4'($urandom_range(0, 3));
        return 4'($urandom_range(0, 15));
    endfunction

    function automatic logic [CODE_W-1:0] pick_code();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return air_now;
        if (r < 80)
            return 8'($urandom_range(1, 3));
        return 8'($urandom_range(0, 255));
    endfunction

    initial begin
        logic [CODE_W-1:0] air_plan [NUM_PHASES];
        logic [POS_W-1:0]  bx, by, bz;
        int                reb_a, reb_b, r;

        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_cmd       <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        air_now      = '0;

        air_plan[0] = 8'hFF;
        air_plan[1] = 8'($urandom_range(0, 255));
        air_plan[2] = 8'h01;
        air_plan[3] = 8'($urandom_range(0, 255));
        air_plan[4] = 8'h00;
        air_plan[5] = 8'($urandom_range(0, 255));
        air_plan[6] = 8'h02;
        air_plan[7] = 8'h00;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset contents, extremes, stale masks, chunk borders
        set_air(8'h00);
        send_cmd(vcfv_pkg::CMD_READ_MASK,  4'd0,  4'd0,  4'd0,  8'h00);
        send_cmd(vcfv_pkg::CMD_READ_TYPE,  4'd15, 4'd15, 4'd15, 8'hFF);
        send_cmd(vcfv_pkg::CMD_WRITE_TYPE, 4'd0,  4'd0,  4'd0,  8'hFF);
        send_cmd(vcfv_pkg::CMD_WRITE_TYPE, 4'd1,  4'd0,  4'd0,  8'h01);
        send_cmd(vcfv_pkg::CMD_WRITE_TYPE, 4'd15, 4'd15, 4'd15, 8'h80);
        send_cmd(vcfv_pkg::CMD_WRITE_TYPE, 4'd15, 4'd14, 4'd15, 8'h7F);
        send_cmd(vcfv_pkg::CMD_WRITE_TYPE, 4'd7,  4'd8,  4'd7,  8'h55);
        send_cmd(vcfv_pkg::CMD_WRITE_TYPE, 4'd7,  4'd7,  4'd8,  8'hAA);
        send_cmd(vcfv_pkg::CMD_READ_TYPE,  4'd0,  4'd0,  4'd0,  8'h00);
        send_cmd(vcfv_pkg::CMD_READ_MASK,  4'd15, 4'd15, 4'd15, 8'h00);
        send_cmd(vcfv_pkg::CMD_REBUILD,    4'd0,  4'd0,  4'd0,  8'h00);
        send_cmd(vcfv_pkg::CMD_READ_MASK,  4'd0,  4'd0,  4'd0,  8'h00);
        send_cmd(vcfv_pkg::CMD_READ_TYPE,  4'd1,  4'd0,  4'd0,  8'h00);
        send_cmd(vcfv_pkg::CMD_READ_MASK,  4'd15, 4'd15, 4'd15, 8'h00);
        send_cmd(vcfv_pkg::CMD_READ_TYPE,  4'd15, 4'd14, 4'd15, 8'h00);
        send_cmd(vcfv_pkg::CMD_READ_MASK,  4'd7,  4'd7,  4'd7,  8'h00);
        send_cmd(vcfv_pkg::CMD_READ_MASK,  4'd7,  4'd8,  4'd7,  8'h00);
        // block cleared to air keeps its old mask until the next rebuild
        send_cmd(vcfv_pkg::CMD_WRITE_TYPE, 4'd0,  4'd0,  4'd0,  8'h00);
        send_cmd(vcfv_pkg::CMD_READ_MASK,  4'd0,  4'd0,  4'd0,  8'h00);

        // random phases, each under an air code from the plan
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            set_air(air_plan[ph]);
            bx = pick_base();
            by = pick_base();
            bz = pick_base();
            reb_a = $urandom_range(15, 55);
            reb_b = $urandom_range(65, 99);
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (k == 50) begin
                    bx = pick_base();
                    by = pick_base();
                    bz = pick_base();
                end
                if (k == reb_a || k == reb_b) begin
                    send_cmd(vcfv_pkg::CMD_REBUILD, 4'($urandom_range(0, 15)),
                             4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                             8'($urandom_range(0, 255)));
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 45)
                        send_cmd(vcfv_pkg::CMD_WRITE_TYPE, pick_coord(bx), pick_coord(by),
                                 pick_coord(bz), pick_code());
                    else if (r < 72)
                        send_cmd(vcfv_pkg::CMD_READ_MASK, pick_coord(bx), pick_coord(by),
                                 pick_coord(bz), 8'($urandom_range(0, 255)));
                    else
                        send_cmd(vcfv_pkg::CMD_READ_TYPE, pick_coord(bx), pick_coord(by),
                                 pick_coord(bz), 8'($urandom_range(0, 255)));
                end
                // sender gaps everywhere but the final phase
                if (ph != NUM_PHASES - 1 && $urandom_range(0, 3) == 0)
                    idle_gap($urandom_range(1, 18));
            end
        end

        settle();

        $display("ran %0d commands: %0d type writes, %0d rebuilds, %0d reads",
                 n_writes + n_rebuilds + n_reads, n_writes, n_rebuilds, n_reads);
        $display("across %0d air code settings, %0d cycles, %0d mismatches",
                 n_air_settings, cycle_count, fail_count);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
